>>> src/lrt_pkg.sv
// ----------------------------------------------------------------------------
// lrt_pkg
// Shared types, codes and default sizes of the line remap table.
// ----------------------------------------------------------------------------
package lrt_pkg;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_LINE_BITS   = 24;
  localparam int DEF_FILE_BITS   = 16;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_ADD   = 2'd0;
  localparam op_t OP_MAP   = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_ORDER = 2'd2;

endpackage

>>> src/lrt_if.sv
// ----------------------------------------------------------------------------
// lrt_in_if / lrt_out_if
// Valid/ready channels carrying requests into and results out of the table.
// ----------------------------------------------------------------------------
interface lrt_in_if #(
  parameter int LINE_BITS = lrt_pkg::DEF_LINE_BITS,
  parameter int FILE_BITS = lrt_pkg::DEF_FILE_BITS
);
  logic                 valid;
  logic                 ready;
  lrt_pkg::op_t         op;
  logic [LINE_BITS-1:0] query_line;
  logic [LINE_BITS-1:0] target_line;
  logic [FILE_BITS-1:0] file_tag;

  modport source (output valid, op, query_line, target_line, file_tag, input ready);
  modport sink   (input valid, op, query_line, target_line, file_tag, output ready);
endinterface

interface lrt_out_if #(
  parameter int LINE_BITS = lrt_pkg::DEF_LINE_BITS,
  parameter int FILE_BITS = lrt_pkg::DEF_FILE_BITS
);
  logic                 valid;
  logic                 ready;
  logic [LINE_BITS-1:0] mapped_line;
  logic [FILE_BITS-1:0] mapped_file;
  logic                 file_found;
  lrt_pkg::status_t     status;

  modport source (output valid, mapped_line, mapped_file, file_found, status, input ready);
  modport sink   (input valid, mapped_line, mapped_file, file_found, status, output ready);
endinterface

>>> src/line_directive_remap_table_unit.sv
// ----------------------------------------------------------------------------
// line_directive_remap_table_unit
// Sorted table of line remap entries with add, map and clear requests.
// ----------------------------------------------------------------------------
// One request is in flight at a time; in_chan.ready is high only while the
// sequencer is idle. Each add or map starts with a binary search over the
// source-line memory, which has one registered read port, so each probe
// issues its read in S_PROBE and compares the data in S_CMP. A map then
// reads the chosen entry (S_ENTRY, S_CALC) and, if that entry carries no
// file id, walks back toward entry 0 (S_WALK, S_CHECK) until it finds one.
// Clear and unused codes skip the search. The finished result sits in an
// output register, and the next request is taken while it waits to be
// transferred.
module line_directive_remap_table_unit #(
  parameter int TABLE_DEPTH = lrt_pkg::DEF_TABLE_DEPTH,
  parameter int LINE_BITS   = lrt_pkg::DEF_LINE_BITS,
  parameter int FILE_BITS   = lrt_pkg::DEF_FILE_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  lrt_in_if.sink     in_chan,
  lrt_out_if.source  out_chan
);
  import lrt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PROBE  = 4'd1;
  localparam logic [3:0] S_CMP    = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_ENTRY  = 4'd4;
  localparam logic [3:0] S_CALC   = 4'd5;
  localparam logic [3:0] S_WALK   = 4'd6;
  localparam logic [3:0] S_CHECK  = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]           state_r,  state_nxt;
  logic [CNT_W-1:0]     count_r,  count_nxt;
  logic [CNT_W-1:0]     lo_r,     lo_nxt;
  logic [CNT_W-1:0]     hi_r,     hi_nxt;
  logic [LINE_BITS-1:0] last_src_r, last_src_nxt;
  logic [IDX_W-1:0]     k_r,      k_nxt;
  op_t                  op_r,     op_nxt;
  logic [LINE_BITS-1:0] q_r,      q_nxt;
  logic [LINE_BITS-1:0] tgt_r,    tgt_nxt;
  logic [FILE_BITS-1:0] fid_r,    fid_nxt;

  logic [LINE_BITS-1:0] res_line_r,   res_line_nxt;
  logic [FILE_BITS-1:0] res_file_r,   res_file_nxt;
  logic                 res_found_r,  res_found_nxt;
  status_t              res_status_r, res_status_nxt;

  logic                 out_valid_r,  out_valid_nxt;
  logic [LINE_BITS-1:0] out_line_r,   out_line_nxt;
  logic [FILE_BITS-1:0] out_file_r,   out_file_nxt;
  logic                 out_found_r,  out_found_nxt;
  status_t              out_status_r, out_status_nxt;

  // Table storage, one read port with registered data
  logic [LINE_BITS-1:0] src_mem  [TABLE_DEPTH];
  logic [LINE_BITS-1:0] tgt_mem  [TABLE_DEPTH];
  logic [FILE_BITS-1:0] file_mem [TABLE_DEPTH];
  logic [LINE_BITS-1:0] rd_src_r;
  logic [LINE_BITS-1:0] rd_tgt_r;
  logic [FILE_BITS-1:0] rd_file_r;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic                 wr_en;
  logic                 wr_src_en;

  logic [CNT_W:0]       mid_sum;
  logic [IDX_W-1:0]     mid;
  logic [CNT_W-1:0]     lo_m1;
  logic [CNT_W-1:0]     lo_m2;
  logic                 hit;
  logic [LINE_BITS-1:0] diff;
  logic [LINE_BITS:0]   sum;
  logic                 in_xfer;
  logic                 out_load;

  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = mid_sum[IDX_W:1];
  assign lo_m1    = lo_r - CNT_W'(1);
  assign lo_m2    = lo_r - CNT_W'(2);
  assign hit      = (lo_r != '0) && (last_src_r == q_r);
  assign diff     = q_r - rd_src_r - LINE_BITS'(1);
  assign sum      = {1'b0, diff} + {1'b0, rd_tgt_r};
  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.mapped_line = out_line_r;
  assign out_chan.mapped_file = out_file_r;
  assign out_chan.file_found  = out_found_r;
  assign out_chan.status      = out_status_r;

  assign rd_addr = ((state_r == S_ENTRY) || (state_r == S_WALK)) ? k_r : mid;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    last_src_nxt   = last_src_r;
    k_nxt          = k_r;
    op_nxt         = op_r;
    q_nxt          = q_r;
    tgt_nxt        = tgt_r;
    fid_nxt        = fid_r;
    res_line_nxt   = res_line_r;
    res_file_nxt   = res_file_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    wr_en          = 1'b0;
    wr_src_en      = 1'b0;
    wr_addr        = count_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt         = in_chan.op;
          q_nxt          = in_chan.query_line;
          tgt_nxt        = in_chan.target_line;
          fid_nxt        = in_chan.file_tag;
          lo_nxt         = '0;
          hi_nxt         = count_r;
          res_line_nxt   = '0;
          res_file_nxt   = '0;
          res_found_nxt  = 1'b0;
          res_status_nxt = STATUS_OK;
          if ((in_chan.op == OP_ADD) || (in_chan.op == OP_MAP)) begin
            state_nxt = S_PROBE;
          end else begin
            if (in_chan.op == OP_CLEAR) begin
              count_nxt = '0;
            end
            state_nxt = S_DONE;
          end
        end
      end
      S_PROBE: begin
        // read at mid is issued here while the window is open
        state_nxt = (lo_r < hi_r) ? S_CMP : S_DECIDE;
      end
      S_CMP: begin
        if (rd_src_r <= q_r) begin
          lo_nxt       = CNT_W'(mid) + CNT_W'(1);
          last_src_nxt = rd_src_r;
        end else begin
          hi_nxt = CNT_W'(mid);
        end
        state_nxt = S_PROBE;
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        if (op_r == OP_ADD) begin
          if (hit) begin
            wr_en   = 1'b1;
            wr_addr = lo_m1[IDX_W-1:0];
          end else if (lo_r != count_r) begin
            res_status_nxt = STATUS_ORDER;
          end else if (count_r == CNT_W'(TABLE_DEPTH)) begin
            res_status_nxt = STATUS_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_src_en = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end else begin
          // map: no predecessor, or only the first entry's directive line
          if ((lo_r == '0) || (hit && (lo_r == CNT_W'(1)))) begin
            res_line_nxt = q_r;
          end else begin
            k_nxt     = hit ? lo_m2[IDX_W-1:0] : lo_m1[IDX_W-1:0];
            state_nxt = S_ENTRY;
          end
        end
      end
      S_ENTRY: begin
        state_nxt = S_CALC;
      end
      S_CALC: begin
        res_line_nxt = sum[LINE_BITS] ? '1 : sum[LINE_BITS-1:0];
        if (rd_file_r != '0) begin
          res_file_nxt  = rd_file_r;
          res_found_nxt = 1'b1;
          state_nxt     = S_DONE;
        end else if (k_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt     = k_r - IDX_W'(1);
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (rd_file_r != '0) begin
          res_file_nxt  = rd_file_r;
          res_found_nxt = 1'b1;
          state_nxt     = S_DONE;
        end else if (k_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt     = k_r - IDX_W'(1);
          state_nxt = S_WALK;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_line_nxt   = out_line_r;
    out_file_nxt   = out_file_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_line_nxt   = res_line_r;
      out_file_nxt   = res_file_r;
      out_found_nxt  = res_found_r;
      out_status_nxt = res_status_r;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    last_src_r   <= last_src_nxt;
    k_r          <= k_nxt;
    op_r         <= op_nxt;
    q_r          <= q_nxt;
    tgt_r        <= tgt_nxt;
    fid_r        <= fid_nxt;
    res_line_r   <= res_line_nxt;
    res_file_r   <= res_file_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    out_line_r   <= out_line_nxt;
    out_file_r   <= out_file_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_src_en) begin
      src_mem[wr_addr] <= q_r;
    end
    if (wr_en) begin
      tgt_mem[wr_addr]  <= tgt_r;
      file_mem[wr_addr] <= fid_r;
    end
    rd_src_r  <= src_mem[rd_addr];
    rd_tgt_r  <= tgt_mem[rd_addr];
    rd_file_r <= file_mem[rd_addr];
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_window_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE || state_r == S_CMP) |-> (lo_r <= hi_r && hi_r <= count_r))
    else $error("search window out of order");

  a_write_in_decide: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_DECIDE && op_r == OP_ADD && res_status_nxt == STATUS_OK))
    else $error("table write outside an accepted add");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_chan.op == OP_CLEAR) |=> (count_r == '0))
    else $error("clear did not empty the table");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == S_IDLE))
    else $error("result load did not complete the request");
`endif

endmodule

>>> tb/tb_line_directive_remap_table_unit.sv
// ----------------------------------------------------------------------------
// tb_line_directive_remap_table_unit
// Self-checking bench for the line remap table. A scoreboard model keeps its
// own sorted table and predicts every add, map and clear. The stimulus is
// directed corner cases, a full table, output backpressure, then random
// request streams, most with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_line_directive_remap_table_unit;
  import lrt_pkg::*;

  localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
  localparam int LINE_BITS   = DEF_LINE_BITS;
  localparam int FILE_BITS   = DEF_FILE_BITS;

  localparam op_t OP_RESERVED     = 2'd3;
  localparam int  HOLD_OFF_CYCLES = 300;
  localparam int  STALL_LIMIT     = 4000;
  localparam int  SETTLE_CYCLES   = 200;
  localparam int  RANDOM_ITEMS    = 650;

  typedef logic [LINE_BITS-1:0] line_t;
  typedef logic [FILE_BITS-1:0] file_t;

  localparam line_t LINE_MAX = '1;

  typedef struct packed {
    line_t   mapped_line;
    file_t   mapped_file;
    logic    file_found;
    status_t status;
  } remap_result_t;

  logic clk;
  logic rst_n;

  lrt_in_if  #(.LINE_BITS(LINE_BITS), .FILE_BITS(FILE_BITS)) in_if ();
  lrt_out_if #(.LINE_BITS(LINE_BITS), .FILE_BITS(FILE_BITS)) out_if ();

  line_directive_remap_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .LINE_BITS  (LINE_BITS),
    .FILE_BITS  (FILE_BITS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  // scoreboard copy of the table
  line_t remap_src  [TABLE_DEPTH];
  line_t remap_tgt  [TABLE_DEPTH];
  file_t remap_file [TABLE_DEPTH];
  int    remap_count = 0;

  remap_result_t awaited_results[$];
  int            error_count    = 0;
  int            result_count   = 0;
  int            accepted_items = 0;
  int            idle_cycles    = 0;
  bit            src_idle_en    = 1'b0;
  bit            sink_idle_en   = 1'b0;
  bit            hold_off_req   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic remap_result_t remap_predict(op_t op, line_t q, line_t t, file_t f);
    remap_result_t    res;
    int               idx;
    int               k;
    longint unsigned  sum;
    res = '0;
    idx = -1;
    case (op)
      OP_ADD: begin
        for (k = 0; k < remap_count; k++)
          if (remap_src[k] == q) idx = k;
        if (idx >= 0) begin
          remap_tgt[idx]  = t;
          remap_file[idx] = f;
        end else if (remap_count > 0 && remap_src[remap_count-1] > q) begin
          res.status = STATUS_ORDER;
        end else if (remap_count >= TABLE_DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          remap_src[remap_count]  = q;
          remap_tgt[remap_count]  = t;
          remap_file[remap_count] = f;
          remap_count++;
        end
      end
      OP_MAP: begin
        res.mapped_line = q;
        for (k = remap_count - 1; k >= 0 && idx < 0; k--)
          if (remap_src[k] <= q) idx = k;
        // a query on the directive line itself uses the entry before it
        if (idx >= 0 && remap_src[idx] == q) idx--;
        if (idx >= 0) begin
          sum = 64'(q) - 64'(remap_src[idx]) - 64'd1 + 64'(remap_tgt[idx]);
          res.mapped_line = (sum > 64'(LINE_MAX)) ? LINE_MAX : line_t'(sum);
          for (k = idx; k >= 0 && !res.file_found; k--) begin
            if (remap_file[k] != '0) begin
              res.mapped_file = remap_file[k];
              res.file_found  = 1'b1;
            end
          end
        end
      end
      OP_CLEAR: remap_count = 0;
      default: ;
    endcase
    return res;
  endfunction

  function automatic line_t rand_line();
    return line_t'($urandom());
  endfunction

  function automatic line_t rand_target();
    case ($urandom_range(0, 3))
      0:       return line_t'($urandom_range(0, 255));
      1:       return LINE_MAX - line_t'($urandom_range(0, 255));
      default: return line_t'($urandom());
    endcase
  endfunction

  function automatic file_t rand_file();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6)  return '0;
    if (pick == 6) return '1;
    return file_t'($urandom());
  endfunction

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Offer one request and hold it until the transfer happens.
  task automatic send_item(op_t op, line_t q, line_t t, file_t f);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.op          <= op;
    in_if.query_line  <= q;
    in_if.target_line <= t;
    in_if.file_tag    <= f;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    awaited_results.push_back(remap_predict(op, q, t, f));
    if (op != OP_RESERVED) accepted_items++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_item(OP_MAP, '0, '0, '0);
    send_item(OP_MAP, LINE_MAX, LINE_MAX, '1);
    send_item(OP_RESERVED, LINE_MAX, LINE_MAX, '1);
    send_item(OP_ADD, 24'd10, 24'd100, '0);
    send_item(OP_MAP, 24'd10, '0, '0);          // directive line of first entry
    send_item(OP_MAP, 24'd5, '0, '0);           // below every entry
    send_item(OP_MAP, 24'd11, '0, '0);          // mapped, no file id anywhere
    send_item(OP_ADD, 24'd20, LINE_MAX, '1);
    send_item(OP_ADD, 24'd15, 24'd1, 16'd1);    // out of order
    send_item(OP_ADD, 24'd10, '0, 16'd7);       // exact match, replace
    send_item(OP_MAP, 24'd20, '0, '0);          // step back one entry
    send_item(OP_MAP, 24'd30, '0, '0);          // saturates
    send_item(OP_ADD, LINE_MAX, 24'd1, '0);
    send_item(OP_MAP, LINE_MAX, '0, '0);
    send_item(OP_ADD, 24'd30, 24'd2, 16'd2);    // out of order
    send_item(OP_MAP, '0, '0, '0);
    send_item(OP_CLEAR, LINE_MAX, LINE_MAX, '1);
    send_item(OP_MAP, LINE_MAX, '0, '0);
    send_item(OP_ADD, '0, '0, '0);
    send_item(OP_MAP, 24'd1, '0, '0);
    send_item(OP_ADD, '0, LINE_MAX, 16'd1);
    send_item(OP_MAP, 24'd2, '0, '0);
    send_item(OP_ADD, 24'd5, 24'd3, '0);
    send_item(OP_MAP, 24'd6, '0, '0);           // file id from the entry before
    send_item(OP_CLEAR, '0, '0, '0);
    drain_results();
  endtask

  // Fill all entries, with a file id on entry 0 only, so maps walk far back.
  task automatic test_full_table();
    line_t base;
    base = line_t'($urandom_range(1, 1000));
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_item(OP_ADD, base + line_t'(5 * i), rand_target(),
                (i == 0) ? file_t'($urandom_range(1, 65535)) : file_t'(0));
    send_item(OP_ADD, base + line_t'(5 * TABLE_DEPTH), rand_target(), rand_file());
    send_item(OP_ADD, LINE_MAX, rand_target(), rand_file());
    send_item(OP_ADD, base + line_t'(16), rand_target(), rand_file());
    send_item(OP_ADD, base + line_t'(5 * (TABLE_DEPTH - 1)), rand_target(), '0);
    send_item(OP_MAP, LINE_MAX, '0, '0);
    send_item(OP_MAP, base + line_t'(5 * (TABLE_DEPTH - 1)), '0, '0);
    send_item(OP_MAP, base, '0, '0);
    send_item(OP_MAP, base - line_t'(1), '0, '0);
    for (int i = 0; i < 8; i++)
      send_item(OP_MAP, base + line_t'($urandom_range(0, 5 * TABLE_DEPTH)), '0, '0);
    drain_results();
  endtask

  // Stall the result side long enough that the block stops taking requests.
  task automatic test_output_backpressure();
    src_idle_en  = 1'b0;
    hold_off_req = 1'b1;
    send_item(OP_CLEAR, '0, '0, '0);
    for (int i = 0; i < 12; i++) begin
      if (i % 2 == 0)
        send_item(OP_ADD, line_t'(i * 100), rand_target(), rand_file());
      else
        send_item(OP_MAP, line_t'($urandom_range(0, 1300)), '0, '0);
    end
    drain_results();
  endtask

  task automatic run_random_stream(int n_items);
    line_t q;
    line_t last;
    line_t gap;
    op_t   op;
    int    k;
    int    pick;
    for (int i = 0; i < n_items; i++) begin
      last = (remap_count > 0) ? remap_src[remap_count-1] : '0;
      k    = (remap_count > 0) ? $urandom_range(0, remap_count - 1) : 0;
      q    = (remap_count > 0) ? remap_src[k] : rand_line();
      op   = OP_ADD;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // in-order append
        case ($urandom_range(0, 3))
          0:       gap = line_t'(1);
          1:       gap = line_t'($urandom_range(2, 16));
          2:       gap = line_t'($urandom_range(17, 4096));
          default: gap = line_t'($urandom_range(4097, 1 << 20));
        endcase
        if (remap_count == 0)
          q = $urandom_range(0, 1) ? line_t'($urandom_range(0, 64)) : rand_line();
        else
          q = (last > LINE_MAX - gap) ? LINE_MAX : last + gap;
      end else if (pick < 70) begin
        op = OP_MAP;
        case ($urandom_range(0, 5))
          0:       ;
          1:       q = q + line_t'(1);
          2:       q = q - line_t'(1);
          3:       q = rand_line();
          4:       q = LINE_MAX;
          default: q = last + line_t'($urandom_range(0, 16));
        endcase
      end else if (pick < 80) begin
        ;  // rewrite an existing entry
      end else if (pick < 88) begin
        q = (last > 0) ? line_t'($urandom_range(0, int'(last) - 1)) : rand_line();
      end else if (pick < 92) begin
        q = rand_line();
      end else if (pick < 95) begin
        op = OP_CLEAR;
        q  = rand_line();
      end else begin
        op = OP_RESERVED;
        q  = rand_line();
      end
      send_item(op, q, rand_target(), rand_file());
    end
  endtask

  task automatic test_random_sequences();
    while (accepted_items < RANDOM_ITEMS) begin
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) send_item(OP_CLEAR, rand_line(), rand_target(), rand_file());
      run_random_stream($urandom_range(20, 120));
      if ($urandom_range(0, 3) == 0) drain_results();
    end
  endtask

  task automatic test_no_idle_tail();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    run_random_stream(100);
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    remap_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (awaited_results.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing outstanding", result_count));
      end else begin
        want = awaited_results.pop_front();
        if (out_if.mapped_line !== want.mapped_line)
          report_error($sformatf("result %0d mapped_line 0x%0h, expected 0x%0h",
                                 result_count, out_if.mapped_line, want.mapped_line));
        if (out_if.mapped_file !== want.mapped_file)
          report_error($sformatf("result %0d mapped_file 0x%0h, expected 0x%0h",
                                 result_count, out_if.mapped_file, want.mapped_file));
        if (out_if.file_found !== want.file_found)
          report_error($sformatf("result %0d file_found %0b, expected %0b",
                                 result_count, out_if.file_found, want.file_found));
        if (out_if.status !== want.status)
          report_error($sformatf("result %0d status %0d, expected %0d",
                                 result_count, out_if.status, want.status));
      end
      result_count++;
    end
  end

  // Abort when no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TIMEOUT: no transfer for %0d cycles", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.op          <= OP_ADD;
    in_if.query_line  <= '0;
    in_if.target_line <= '0;
    in_if.file_tag    <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_full_table();
    test_output_backpressure();
    test_random_sequences();
    test_no_idle_tail();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
